@@ hw/rtl/rtic_pkg.sv @@
// ----------------------------------------------------------------------------
// rtic_pkg: shared types and constants of the ray/triangle intersection core
// Widths of coordinates, products and dot sums, queue geometry and the
// structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package rtic_pkg;

  // Packed vector format: three signed coordinates, x in the low bits
  localparam int COORD_BITS = 21;
  localparam int PKD_W      = 63;

  // Configuration port
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 1'd1;
  localparam int THR_W  = 20;
  localparam int DIST_W = 31;
  localparam int NRM_W  = 16;

  // Front end arithmetic
  localparam int E_W   = COORD_BITS + 1;   // edge / offset vectors
  localparam int PRD_W = 2 * E_W;          // one cross product term
  localparam int X_W   = PRD_W + 1;        // cross product component
  localparam int LO_W  = E_W;              // low slice of a cross component
  localparam int HI_W  = X_W - LO_W;       // high slice (signed)
  localparam int LP_W  = E_W + LO_W + 1;   // low partial product
  localparam int HP_W  = E_W + HI_W;       // high partial product
  localparam int DW    = E_W + X_W + 2;    // determinant and numerators
  localparam int DW1   = DW + 1;

  // Back end arithmetic
  localparam int DIST_FRAC  = 16;
  localparam int DIV_STEPS  = DIST_W;
  localparam int NUM_W      = DW + DIV_STEPS;
  localparam int MAG_W      = X_W;
  localparam int SQ_LO      = (MAG_W + 1) / 2;
  localparam int SQ_HI      = MAG_W - SQ_LO;
  localparam int PP_W       = 2 * SQ_LO;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SS_W       = SQ_W + 2;
  localparam int NRM_FRAC   = 14;
  localparam int RT_STEPS   = NRM_FRAC + 1;
  localparam int TGT_SHIFT  = 2 * NRM_FRAC;
  localparam int P_W        = SS_W + 2 * RT_STEPS + 2;
  localparam int Q_W        = SS_W + RT_STEPS;

  // Back end stage plan
  localparam int BK_SAT     = 1;
  localparam int BK_SQ      = 2;
  localparam int BK_SS      = 3;
  localparam int BK_RT0     = 4;
  localparam int BK_RT_LAST = BK_RT0 + RT_STEPS - 1;
  localparam int BK_DIV0    = 2;
  localparam int BK_DIV_LAST = BK_DIV0 + DIV_STEPS - 1;
  localparam int BK_LAST    = BK_DIV_LAST + 1;

  // Queue between front and back
  localparam int Q_DEPTH = 16;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  typedef struct packed {
    logic                      ok;
    logic [DW-1:0]             a;
    logic [DW-1:0]             tn;
    logic [2:0][X_W-1:0]       n;
  } rtic_qent_t;

  typedef struct packed {
    logic       vld;
    rtic_qent_t ent;
  } rtic_req_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [DIST_W-1:0] min_dist;
  } rtic_cfg_t;

  typedef struct packed {
    logic                    vld;
    logic                    hit;
    logic [DIST_W-1:0]       distance;
    logic [2:0][NRM_W-1:0]   nrm;
  } rtic_res_t;

endpackage

@@ hw/rtl/rtic_front.sv @@
// ----------------------------------------------------------------------------
// rtic_front: edge vectors, cross products, dot products and hit test
// Seven-stage free-running pipeline; one request may enter every cycle.
// ----------------------------------------------------------------------------
module rtic_front import rtic_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [PKD_W-1:0] in_org,
  input  logic [PKD_W-1:0] in_dir,
  input  logic [PKD_W-1:0] in_v0,
  input  logic [PKD_W-1:0] in_v1,
  input  logic [PKD_W-1:0] in_v2,
  input  rtic_cfg_t        cfg,
  output rtic_req_t        push
);

  localparam int X_H = 0;
  localparam int X_Q = 1;
  localparam int X_N = 2;
  localparam int D_A  = 0;
  localparam int D_UN = 1;
  localparam int D_VN = 2;
  localparam int D_TN = 3;
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  logic [6:0] vld_r;

  logic signed [E_W-1:0]  d_r  [3][3];
  logic signed [E_W-1:0]  e1_r [3][3];
  logic signed [E_W-1:0]  e2_r [3][3];
  logic signed [E_W-1:0]  s_r  [3][3];
  logic signed [PRD_W-1:0] pl_r [3][3];
  logic signed [PRD_W-1:0] pr_r [3][3];
  logic signed [X_W-1:0]  cx_r [3][3];
  logic signed [LP_W-1:0] dl_r [4][3];
  logic signed [HP_W-1:0] dh_r [4][3];
  logic signed [X_W-1:0]  n_r  [4][3];
  logic signed [DW-1:0]   dot_r [4];
  logic signed [DW-1:0]   nrm_r [4];
  logic                   ok_r;
  logic [DW-1:0]          a_r;
  logic [DW-1:0]          tn_r;

  logic signed [E_W-1:0] xa [3][3];
  logic signed [E_W-1:0] xb [3][3];
  logic signed [E_W-1:0] du [4][3];
  logic signed [X_W-1:0] dw [4][3];
  logic signed [DW-1:0]  hsum [4];
  logic signed [DW-1:0]  lsum [4];
  logic                  ok_nxt;
  logic signed [DW1-1:0] uv;

  function automatic logic signed [E_W-1:0] crd(input logic [PKD_W-1:0] v, input int k);
    return E_W'($signed(v[k*COORD_BITS +: COORD_BITS]));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  // cross operands: h = d x e2, q = s x e1, n = e1 x e2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xa[X_H][i] = d_r[0][i];  xb[X_H][i] = e2_r[0][i];
      xa[X_Q][i] = s_r[0][i];  xb[X_Q][i] = e1_r[0][i];
      xa[X_N][i] = e1_r[0][i]; xb[X_N][i] = e2_r[0][i];
    end
  end

  // dot operands: a = e1.h, un = s.h, vn = d.q, tn = e2.q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du[D_A][i]  = e1_r[2][i]; dw[D_A][i]  = cx_r[X_H][i];
      du[D_UN][i] = s_r[2][i];  dw[D_UN][i] = cx_r[X_H][i];
      du[D_VN][i] = d_r[2][i];  dw[D_VN][i] = cx_r[X_Q][i];
      du[D_TN][i] = e2_r[2][i]; dw[D_TN][i] = cx_r[X_Q][i];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      hsum[j] = DW'(dh_r[j][0]) + DW'(dh_r[j][1]) + DW'(dh_r[j][2]);
      lsum[j] = DW'(dl_r[j][0]) + DW'(dl_r[j][1]) + DW'(dl_r[j][2]);
    end
  end

  // hit test on sign-normalized values
  always_comb begin
    uv = DW1'(nrm_r[D_UN]) + DW1'(nrm_r[D_VN]);
    ok_nxt = (nrm_r[D_A] != '0) && !(nrm_r[D_A] < $signed(DW'(cfg.thr)))
          && !nrm_r[D_UN][DW-1] && !(nrm_r[D_UN] > nrm_r[D_A])
          && !nrm_r[D_VN][DW-1] && !(uv > DW1'(nrm_r[D_A]))
          && !nrm_r[D_TN][DW-1] && (nrm_r[D_TN] != '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      // F0: edges and origin offset
      d_r[0][i]  <= crd(in_dir, i);
      e1_r[0][i] <= crd(in_v1, i) - crd(in_v0, i);
      e2_r[0][i] <= crd(in_v2, i) - crd(in_v0, i);
      s_r[0][i]  <= crd(in_org, i) - crd(in_v0, i);
      for (int t = 1; t < 3; t++) begin
        d_r[t][i]  <= d_r[t-1][i];
        e1_r[t][i] <= e1_r[t-1][i];
        e2_r[t][i] <= e2_r[t-1][i];
        s_r[t][i]  <= s_r[t-1][i];
      end
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        // F1: cross product terms
        pl_r[c][i] <= PRD_W'(xa[c][NXT1[i]]) * PRD_W'(xb[c][NXT2[i]]);
        pr_r[c][i] <= PRD_W'(xa[c][NXT2[i]]) * PRD_W'(xb[c][NXT1[i]]);
        // F2: cross components
        cx_r[c][i] <= X_W'(pl_r[c][i]) - X_W'(pr_r[c][i]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        // F3: split partial products of the dot terms
        dl_r[j][i] <= LP_W'(du[j][i]) * LP_W'($signed({1'b0, dw[j][i][LO_W-1:0]}));
        dh_r[j][i] <= HP_W'(du[j][i]) * HP_W'($signed(dw[j][i][X_W-1:LO_W]));
      end
      // F4: recombine
      dot_r[j] <= (hsum[j] <<< LO_W) + lsum[j];
      // F5: force a positive determinant
      nrm_r[j] <= dot_r[D_A][DW-1] ? -dot_r[j] : dot_r[j];
    end
    for (int i = 0; i < 3; i++) begin
      n_r[0][i] <= cx_r[X_N][i];
      for (int t = 1; t < 4; t++) begin
        n_r[t][i] <= n_r[t-1][i];
      end
    end
    // F6: classify
    ok_r <= ok_nxt;
    a_r  <= nrm_r[D_A];
    tn_r <= nrm_r[D_TN];
  end

  always_comb begin
    push.vld    = vld_r[6];
    push.ent.ok = ok_r;
    push.ent.a  = a_r;
    push.ent.tn = tn_r;
    for (int i = 0; i < 3; i++) begin
      push.ent.n[i] = n_r[3][i];
    end
  end

endmodule

@@ hw/rtl/rtic_queue.sv @@
// ----------------------------------------------------------------------------
// rtic_queue: request queue between front and back end
// Holds classified requests; tracks credits so the front never overflows it.
// ----------------------------------------------------------------------------
module rtic_queue import rtic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  rtic_req_t push,
  input  logic      pop,
  output rtic_req_t head,
  output logic      full
);

  rtic_qent_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_CW-1:0]  fill_r;
  logic [Q_CW-1:0]  fill_nxt;
  logic [Q_CW-1:0]  cred_r;
  logic [Q_CW-1:0]  cred_nxt;
  logic             pop_eff;

  assign pop_eff  = pop && (fill_r != '0);
  assign fill_nxt = fill_r + Q_CW'(push.vld) - Q_CW'(pop_eff);
  assign cred_nxt = cred_r + Q_CW'(acc) - Q_CW'(pop_eff);
  assign full     = (cred_r == Q_CW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      cred_r   <= '0;
    end else begin
      if (push.vld) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_eff) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
      cred_r <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.ent;
    end
  end

  assign head.vld = (fill_r != '0);
  assign head.ent = mem_r[rd_ptr_r];

endmodule

@@ hw/rtl/rtic_back.sv @@
// ----------------------------------------------------------------------------
// rtic_back: distance division and unit normal
// Restoring divider one quotient bit per stage, normal by bitwise root search.
// ----------------------------------------------------------------------------
module rtic_back import rtic_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  rtic_req_t head,
  input  rtic_cfg_t cfg,
  input  logic      out_stall,
  output logic      pop,
  output rtic_res_t res
);

  typedef struct packed {
    logic                     vld;
    logic                     ok;
    logic                     sat;
    logic [DW-1:0]            a;
    logic [NUM_W-1:0]         num;
    logic [DIST_W-1:0]        quo;
    logic [2:0]               neg;
    logic [2:0][MAG_W-1:0]    mag;
    logic [2:0][PP_W-1:0]     pa;
    logic [2:0][PP_W-1:0]     pb;
    logic [2:0][PP_W-1:0]     pc;
    logic [2:0][SQ_W-1:0]     sq;
    logic [SS_W-1:0]          ss;
    logic [2:0][P_W-1:0]      pm;
    logic [2:0][Q_W-1:0]      qm;
    logic [2:0][RT_STEPS-1:0] m;
    logic                     hit;
    logic [DIST_W-1:0]        o_dist;
    logic [2:0][NRM_W-1:0]    o_n;
  } bk_t;

  bk_t  st_r [BK_LAST+1];
  logic adv;

  function automatic bk_t bk_load(input rtic_req_t h);
    bk_t r;
    r     = '0;
    r.vld = h.vld;
    r.ok  = h.ent.ok;
    r.a   = h.ent.a;
    r.num = NUM_W'(h.ent.tn) << DIST_FRAC;
    for (int i = 0; i < 3; i++) begin
      r.neg[i] = h.ent.n[i][X_W-1];
      r.mag[i] = h.ent.n[i][X_W-1] ? (~h.ent.n[i] + 1'b1) : h.ent.n[i];
    end
    return r;
  endfunction

  function automatic bk_t bk_step(input bk_t s, input int k, input logic [DIST_W-1:0] min_d);
    bk_t               r;
    int                b;
    logic [SQ_HI-1:0]  hi;
    logic [SQ_LO-1:0]  lo;
    logic [P_W-1:0]    trial;
    logic [P_W-1:0]    tgt;
    logic [NUM_W-1:0]  part;
    r = s;
    if (k == BK_SAT) begin
      r.sat = (s.num >= (NUM_W'(s.a) << DIV_STEPS));
      for (int i = 0; i < 3; i++) begin
        hi = s.mag[i][MAG_W-1:SQ_LO];
        lo = s.mag[i][SQ_LO-1:0];
        r.pa[i] = PP_W'(hi) * PP_W'(hi);
        r.pb[i] = PP_W'(hi) * PP_W'(lo);
        r.pc[i] = PP_W'(lo) * PP_W'(lo);
      end
    end
    if (k == BK_SQ) begin
      for (int i = 0; i < 3; i++) begin
        r.sq[i] = (SQ_W'(s.pa[i]) << (2 * SQ_LO)) + (SQ_W'(s.pb[i]) << (SQ_LO + 1))
                + SQ_W'(s.pc[i]);
      end
    end
    if (k == BK_SS) begin
      r.ss = SS_W'(s.sq[0]) + SS_W'(s.sq[1]) + SS_W'(s.sq[2]);
      r.pm = '0;
      r.qm = '0;
      r.m  = '0;
    end
    if (k >= BK_RT0 && k <= BK_RT_LAST) begin
      // try one more root bit: ss*(m+2^b)^2 from running ss*m^2 and ss*m
      b = BK_RT_LAST - k;
      for (int i = 0; i < 3; i++) begin
        trial = s.pm[i] + (P_W'(s.qm[i]) << (b + 1)) + (P_W'(s.ss) << (2 * b));
        tgt   = P_W'(s.sq[i]) << TGT_SHIFT;
        if (trial <= tgt) begin
          r.m[i]  = s.m[i] | (RT_STEPS'(1) << b);
          r.pm[i] = trial;
          r.qm[i] = s.qm[i] + (Q_W'(s.ss) << b);
        end
      end
    end
    if (k >= BK_DIV0 && k <= BK_DIV_LAST) begin
      b    = BK_DIV_LAST - k;
      part = NUM_W'(s.a) << b;
      if (s.num >= part) begin
        r.num    = s.num - part;
        r.quo[b] = 1'b1;
      end
    end
    if (k == BK_LAST) begin
      r.hit = s.ok && (s.sat || (s.quo > min_d) || ((s.quo == min_d) && (s.num != '0)));
      r.o_dist = !r.hit ? '0 : (s.sat ? {DIST_W{1'b1}} : s.quo);
      for (int i = 0; i < 3; i++) begin
        if (!r.hit || (s.ss == '0)) begin
          r.o_n[i] = '0;
        end else if (s.neg[i]) begin
          r.o_n[i] = -NRM_W'(s.m[i]);
        end else begin
          r.o_n[i] = NRM_W'(s.m[i]);
        end
      end
    end
    return r;
  endfunction

  // advance the whole back end when the result register is free
  assign adv = !st_r[BK_LAST].vld || !out_stall;
  assign pop = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (adv) begin
      st_r[0] <= bk_load(head);
    end
  end

  for (genvar k = 1; k <= BK_LAST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (adv) begin
        st_r[k] <= bk_step(st_r[k-1], k, cfg.min_dist);
      end
    end
  end

  assign res.vld      = st_r[BK_LAST].vld;
  assign res.hit      = st_r[BK_LAST].hit;
  assign res.distance = st_r[BK_LAST].o_dist;
  assign res.nrm      = st_r[BK_LAST].o_n;

endmodule

@@ hw/rtl/ray_triangle_intersect_core.sv @@
// Throughput: one request per cycle while out_stall is low, set by the fully
//   pipelined front and back end (31 divider, 15 root stages, all overlapped).
// Reset: synchronous, active low; clears valid bits, queue pointers and credits,
//   and loads det_threshold = 1, min_distance = 0.
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core: fixed-point ray/triangle hit test
// Front end computes determinant and numerators and classifies each request;
// a 16-entry queue decouples it from the back end, which divides out the
// distance and normalizes the face normal.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core import rtic_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PKD_W-1:0]        in_ray_origin,
  input  logic [PKD_W-1:0]        in_ray_direction,
  input  logic [PKD_W-1:0]        in_vertex_zero,
  input  logic [PKD_W-1:0]        in_vertex_one,
  input  logic [PKD_W-1:0]        in_vertex_two,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [DIST_W-1:0]       out_distance,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [THR_W-1:0]  thr_r;
  logic [DIST_W-1:0] min_dist_r;
  rtic_cfg_t         cfg;
  logic              acc;
  logic              q_full;
  logic              pop;
  rtic_req_t         push;
  rtic_req_t         head;
  rtic_res_t         res;

  // Config registers; user must write only while core is idle, not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_W'(1);
      min_dist_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DET_THRESHOLD: thr_r      <= cfg_data[THR_W-1:0];
        CFG_MIN_DISTANCE:  min_dist_r <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.thr      = thr_r;
  assign cfg.min_dist = min_dist_r;

  // Hold off requests only when every queue slot is spoken for by a request
  // either still in the front end or already waiting in the queue.
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  rtic_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (acc),
    .in_org (in_ray_origin),
    .in_dir (in_ray_direction),
    .in_v0  (in_vertex_zero),
    .in_v1  (in_vertex_one),
    .in_v2  (in_vertex_two),
    .cfg    (cfg),
    .push   (push)
  );

  rtic_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // Back end advances as one pipeline whenever its last stage, which is the
  // result register, is empty or being taken.
  rtic_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .cfg       (cfg),
    .out_stall (out_stall),
    .pop       (pop),
    .res       (res)
  );

  assign out_valid    = res.vld;
  assign out_hit      = res.hit;
  assign out_distance = res.distance;
  assign out_normal_x = res.nrm[0];
  assign out_normal_y = res.nrm[1];
  assign out_normal_z = res.nrm[2];

endmodule
